// ===== rtl/m7qp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and constant functions for the quad projection block.
// Holds the quarter-wave sine table, which is built at elaboration. No dependencies.
package m7qp_pkg;

  localparam int FRAC_BITS          = 12;
  localparam int SINCOS_TABLE_DEPTH = 1024;

  localparam int DEPTH_BITS = $clog2(SINCOS_TABLE_DEPTH);
  localparam int QTR        = SINCOS_TABLE_DEPTH / 4;
  localparam int QTR_BITS   = DEPTH_BITS - 2;

  localparam int              TURN_UNITS  = 23040;
  localparam int              HALF_TURN   = TURN_UNITS / 2;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1073741824;
  localparam longint unsigned DEPTH_HALF  = SINCOS_TABLE_DEPTH / 2;

  // Divisors (2k)(2k+1) of the sine series terms, k = 1 to 6.
  localparam longint unsigned SERIES_DIV [6] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                 64'd110, 64'd156};

  localparam int FIELD_W  = 16;
  localparam int SIZE_W   = 13;
  localparam int SCREEN_W = 32;
  localparam int CW       = 20;
  localparam int TRIG_W   = 32;
  localparam int PROD_W   = CW + TRIG_W;

  localparam int ONE  = 1 << FRAC_BITS;
  localparam int HALF = 1 << (FRAC_BITS - 1);
  localparam int ZMIN = (ONE + 5) / 10;

  localparam int ANG_POS_W   = 17;
  localparam int ANG_N_W     = ANG_POS_W + DEPTH_BITS + 1;
  localparam int ANG_Q_W     = ANG_N_W - 13;
  localparam int RECIP_SHIFT = 44;
  localparam logic [31:0] RECIP = 32'((64'd1 << RECIP_SHIFT) / TURN_UNITS);

  localparam int MAG_W = CW + FIELD_W + SIZE_W;
  localparam int DIV_W = MAG_W + 9;
  localparam int DVS_W = CW - 1 + FRAC_BITS;
  localparam int QUO_W = DIV_W - FRAC_BITS;
  localparam int EXT_W = DVS_W + QUO_W;

  localparam int LAT_ANGLE = 3;
  localparam int LAT_ROT   = 2;
  localparam int LAT_PROJ  = QUO_W + 3;

  localparam logic [1:0]        CORNER_LAST     = 2'd3;
  localparam logic [SIZE_W-1:0] SCREEN_WIDTH_RST  = 13'd640;
  localparam logic [SIZE_W-1:0] SCREEN_HEIGHT_RST = 13'd480;

  typedef enum logic [1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] sin_v;
    logic signed [TRIG_W-1:0] cos_v;
  } trig_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] cam_x;
    logic signed [FIELD_W-1:0] cam_y;
    logic signed [FIELD_W-1:0] cam_z;
    logic signed [FIELD_W-1:0] angle_x;
    logic signed [FIELD_W-1:0] angle_y;
    logic signed [FIELD_W-1:0] angle_z;
    logic signed [FIELD_W-1:0] focal;
    logic signed [FIELD_W-1:0] src_center_x;
    logic signed [FIELD_W-1:0] src_center_y;
    logic signed [FIELD_W-1:0] src_width;
    logic signed [FIELD_W-1:0] src_height;
  } item_t;

  typedef struct packed {
    logic                      valid;
    logic [1:0]                corner;
    logic                      last;
    logic signed [FIELD_W-1:0] tex_u;
    logic signed [FIELD_W-1:0] tex_v;
  } side_t;

  typedef logic [30:0] sin_mag_t;
  typedef sin_mag_t sin_tab_t [QTR+1];

  // Magnitude of the sine at table step r of a quarter turn, unsigned Q1.30, by a fixed series.
  function automatic sin_mag_t sine_mag(input int unsigned r);
    longint unsigned rem;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    rem  = longint'(r) * 4;
    x    = (rem * HALF_PI_Q30 + DEPTH_HALF) / SINCOS_TABLE_DEPTH;
    x2   = (x * x + (64'd1 << 29)) >> 30;
    term = x;
    sum  = longint'(x);
    for (int k = 1; k <= 6; k++) begin
      term = ((term * x2) >> 30) / SERIES_DIV[k-1];
      if (k[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum > longint'(ONE_Q30)) begin
      sum = longint'(ONE_Q30);
    end
    if (sum < 0) begin
      sum = 0;
    end
    return sin_mag_t'(sum);
  endfunction

  function automatic sin_tab_t sin_tab_build();
    sin_tab_t tab;
    for (int unsigned r = 0; r <= QTR; r++) begin
      tab[r] = sine_mag(r);
    end
    return tab;
  endfunction

  localparam sin_tab_t SIN_TAB = sin_tab_build();

  function automatic logic signed [TRIG_W-1:0] trig_lookup(input logic [1:0] quad,
                                                           input logic [QTR_BITS-1:0] rem);
    logic [QTR_BITS:0]        ti;
    logic signed [TRIG_W-1:0] mag;
    ti  = quad[0] ? (QTR_BITS+1)'(QTR) - {1'b0, rem} : {1'b0, rem};
    mag = TRIG_W'({1'b0, SIN_TAB[ti]});
    return quad[1] ? -mag : mag;
  endfunction

  function automatic logic signed [FIELD_W-1:0] sat16(input logic signed [17:0] v);
    logic signed [17:0] h;
    h = (v + 18'sd1) >>> 1;
    if (h > 18'sd32767) begin
      return 16'sh7FFF;
    end else if (h < -18'sd32768) begin
      return 16'sh8000;
    end
    return h[FIELD_W-1:0];
  endfunction

endpackage

// ===== rtl/mode7_quad_projection.sv =====
`timescale 1ns / 1ps
// Projects the four corners of one textured quad per input word and emits one corner word
// per clock while the output is not stalled, corner 0 to 3, the fourth flagged last; a new
// input word is taken as the corner sequencer sends out the last corner of the word before,
// and each corner passes angle lookup, three rotations, projection and divide, and the
// sequencer and output registers. The whole pipeline holds while a valid output is stalled.
// Uses m7qp_pkg, m7qp_angle, m7qp_rot and m7qp_proj.
module mode7_quad_projection import m7qp_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [SIZE_W-1:0]          cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [FIELD_W-1:0]  in_cam_x,
  input  logic signed [FIELD_W-1:0]  in_cam_y,
  input  logic signed [FIELD_W-1:0]  in_cam_z,
  input  logic signed [FIELD_W-1:0]  in_angle_x,
  input  logic signed [FIELD_W-1:0]  in_angle_y,
  input  logic signed [FIELD_W-1:0]  in_angle_z,
  input  logic signed [FIELD_W-1:0]  in_focal,
  input  logic signed [FIELD_W-1:0]  in_src_center_x,
  input  logic signed [FIELD_W-1:0]  in_src_center_y,
  input  logic signed [FIELD_W-1:0]  in_src_width,
  input  logic signed [FIELD_W-1:0]  in_src_height,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 out_corner,
  output logic signed [SCREEN_W-1:0] out_screen_x,
  output logic signed [SCREEN_W-1:0] out_screen_y,
  output logic signed [FIELD_W-1:0]  out_tex_u,
  output logic signed [FIELD_W-1:0]  out_tex_v,
  output logic                       out_last
);

  localparam int FOC_N  = LAT_ANGLE + 3 * LAT_ROT;
  localparam int SIDE_N = 1 + FOC_N + LAT_PROJ;

  logic [SIZE_W-1:0] screen_width_r;
  logic [SIZE_W-1:0] screen_height_r;

  item_t      item_r;
  logic       have_r;
  logic [1:0] cnt_r;
  logic       en;
  logic       accept;
  logic       emit;
  logic       ox;
  logic       oy;

  coord_t                    x0_nxt, y0_nxt, z0_nxt;
  coord_t                    x0_r, y0_r, z0_r;
  logic signed [FIELD_W-1:0] angx0_r, angy0_r, angz0_r, focal0_r;
  side_t                     side_nxt;
  side_t                     side_r [SIDE_N];

  coord_t cx_r [LAT_ANGLE];
  coord_t cy_r [LAT_ANGLE];
  coord_t cz_r [LAT_ANGLE];
  coord_t xw_r [LAT_ROT];
  coord_t yw_r [LAT_ROT];
  coord_t zw_r [LAT_ROT];
  trig_t  ty_r [LAT_ROT];
  trig_t  tz_r [2*LAT_ROT];
  logic signed [FIELD_W-1:0] fd_r [FOC_N];

  trig_t  trig_x, trig_y, trig_z;
  coord_t y1, z1, z2, x2, x3, y3;
  logic signed [SCREEN_W-1:0] res_x, res_y;

  logic                       out_valid_r;
  logic [1:0]                 out_corner_r;
  logic signed [SCREEN_W-1:0] out_screen_x_r;
  logic signed [SCREEN_W-1:0] out_screen_y_r;
  logic signed [FIELD_W-1:0]  out_tex_u_r;
  logic signed [FIELD_W-1:0]  out_tex_v_r;
  logic                       out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_width_r  <= SCREEN_WIDTH_RST;
      screen_height_r <= SCREEN_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SCREEN_WIDTH:  screen_width_r  <= cfg_wdata;
        REG_SCREEN_HEIGHT: screen_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign en       = !out_valid_r || !out_stall;
  assign emit     = have_r && en;
  assign in_stall = have_r && !(en && cnt_r == CORNER_LAST);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (accept) begin
        have_r <= 1'b1;
      end else if (emit && cnt_r == CORNER_LAST) begin
        have_r <= 1'b0;
      end
      if (emit) begin
        cnt_r <= cnt_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.cam_x        <= in_cam_x;
      item_r.cam_y        <= in_cam_y;
      item_r.cam_z        <= in_cam_z;
      item_r.angle_x      <= in_angle_x;
      item_r.angle_y      <= in_angle_y;
      item_r.angle_z      <= in_angle_z;
      item_r.focal        <= in_focal;
      item_r.src_center_x <= in_src_center_x;
      item_r.src_center_y <= in_src_center_y;
      item_r.src_width    <= in_src_width;
      item_r.src_height   <= in_src_height;
    end
  end

  // Corner order 0..3 walks (0,0) (0,1) (1,1) (1,0).
  always_comb begin
    ox     = cnt_r[1];
    oy     = cnt_r[1] ^ cnt_r[0];
    x0_nxt = (ox ? CW'(ONE) : '0) + CW'(HALF) - CW'(item_r.cam_x);
    y0_nxt = (oy ? CW'(ONE) : '0) + CW'(HALF) - CW'(item_r.cam_y);
    z0_nxt = CW'(item_r.cam_z);
    side_nxt.valid  = have_r;
    side_nxt.corner = cnt_r;
    side_nxt.last   = (cnt_r == CORNER_LAST);
    side_nxt.tex_u  = sat16(18'(item_r.src_center_x) * 18'sd2 +
                            (ox ? 18'(item_r.src_width) : -18'(item_r.src_width)));
    side_nxt.tex_v  = sat16(18'(item_r.src_center_y) * 18'sd2 +
                            (oy ? 18'(item_r.src_height) : -18'(item_r.src_height)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SIDE_N; i++) begin
        side_r[i] <= '0;
      end
    end else if (en) begin
      side_r[0] <= side_nxt;
      for (int i = 1; i < SIDE_N; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0_r     <= x0_nxt;
      y0_r     <= y0_nxt;
      z0_r     <= z0_nxt;
      angx0_r  <= item_r.angle_x;
      angy0_r  <= item_r.angle_y;
      angz0_r  <= item_r.angle_z;
      focal0_r <= item_r.focal;
      cx_r[0]  <= x0_r;
      cy_r[0]  <= y0_r;
      cz_r[0]  <= z0_r;
      for (int i = 1; i < LAT_ANGLE; i++) begin
        cx_r[i] <= cx_r[i-1];
        cy_r[i] <= cy_r[i-1];
        cz_r[i] <= cz_r[i-1];
      end
      xw_r[0] <= cx_r[LAT_ANGLE-1];
      yw_r[0] <= y1;
      zw_r[0] <= z2;
      ty_r[0] <= trig_y;
      for (int i = 1; i < LAT_ROT; i++) begin
        xw_r[i] <= xw_r[i-1];
        yw_r[i] <= yw_r[i-1];
        zw_r[i] <= zw_r[i-1];
        ty_r[i] <= ty_r[i-1];
      end
      tz_r[0] <= trig_z;
      for (int i = 1; i < 2 * LAT_ROT; i++) begin
        tz_r[i] <= tz_r[i-1];
      end
      fd_r[0] <= focal0_r;
      for (int i = 1; i < FOC_N; i++) begin
        fd_r[i] <= fd_r[i-1];
      end
    end
  end

  m7qp_angle u_angle_x (.clk(clk), .en(en), .angle(angx0_r), .trig(trig_x));
  m7qp_angle u_angle_y (.clk(clk), .en(en), .angle(angy0_r), .trig(trig_y));
  m7qp_angle u_angle_z (.clk(clk), .en(en), .angle(angz0_r), .trig(trig_z));

  m7qp_rot u_rot_x (
    .clk(clk), .en(en), .a(cy_r[LAT_ANGLE-1]), .b(cz_r[LAT_ANGLE-1]), .trig(trig_x),
    .a_rot(y1), .b_rot(z1)
  );

  m7qp_rot u_rot_y (
    .clk(clk), .en(en), .a(z1), .b(xw_r[LAT_ROT-1]), .trig(ty_r[LAT_ROT-1]),
    .a_rot(z2), .b_rot(x2)
  );

  m7qp_rot u_rot_z (
    .clk(clk), .en(en), .a(x2), .b(yw_r[LAT_ROT-1]), .trig(tz_r[2*LAT_ROT-1]),
    .a_rot(x3), .b_rot(y3)
  );

  m7qp_proj u_proj_x (
    .clk(clk), .en(en), .p(x3), .z(zw_r[LAT_ROT-1]), .focal(fd_r[FOC_N-1]),
    .size(screen_width_r), .res(res_x)
  );

  m7qp_proj u_proj_y (
    .clk(clk), .en(en), .p(y3), .z(zw_r[LAT_ROT-1]), .focal(fd_r[FOC_N-1]),
    .size(screen_height_r), .res(res_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= side_r[SIDE_N-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_corner_r   <= side_r[SIDE_N-1].corner;
      out_last_r     <= side_r[SIDE_N-1].last;
      out_tex_u_r    <= side_r[SIDE_N-1].tex_u;
      out_tex_v_r    <= side_r[SIDE_N-1].tex_v;
      out_screen_x_r <= res_x;
      out_screen_y_r <= res_y;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_corner   = out_corner_r;
  assign out_screen_x = out_screen_x_r;
  assign out_screen_y = out_screen_y_r;
  assign out_tex_u    = out_tex_u_r;
  assign out_tex_v    = out_tex_v_r;
  assign out_last     = out_last_r;

  a_idle_takes: assert property (@(posedge clk) disable iff (!rst_n)
    !have_r |-> !in_stall)
    else $error("input stalled with an empty word register");

  a_accept_holds: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> have_r)
    else $error("accepted word not held for corner expansion");

  a_count_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (have_r && !en) |=> $stable(cnt_r))
    else $error("corner counter moved while the pipeline was held");

endmodule

// ===== rtl/m7qp_angle.sv =====
`timescale 1ns / 1ps
// Angle to sine and cosine: index quantization by reciprocal multiply, then table lookup.
// Three register stages. Depends on m7qp_pkg.
module m7qp_angle import m7qp_pkg::*; (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [FIELD_W-1:0] angle,
  output trig_t                     trig
);

  logic [ANG_POS_W-1:0]        pos;
  logic [ANG_N_W-1:0]          n;
  logic [ANG_N_W+31:0]         prod;
  logic [ANG_N_W-1:0]          n_r;
  logic [ANG_Q_W-1:0]          q0_r;
  logic [ANG_N_W-1:0]          r;
  logic [DEPTH_BITS-1:0]       idx_nxt;
  logic [DEPTH_BITS-1:0]       idx_r;
  trig_t                       trig_r;

  always_comb begin
    pos  = ANG_POS_W'(angle) + ANG_POS_W'(2 * TURN_UNITS);
    n    = ANG_N_W'({pos, {DEPTH_BITS{1'b0}}}) + ANG_N_W'(HALF_TURN);
    prod = (ANG_N_W+32)'(n) * (ANG_N_W+32)'(RECIP);
    r    = n_r - ANG_N_W'(q0_r) * ANG_N_W'(TURN_UNITS);
    if (r >= ANG_N_W'(TURN_UNITS)) begin
      idx_nxt = DEPTH_BITS'(q0_r + ANG_Q_W'(1));
    end else begin
      idx_nxt = DEPTH_BITS'(q0_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r          <= n;
      q0_r         <= ANG_Q_W'(prod >> RECIP_SHIFT);
      idx_r        <= idx_nxt;
      trig_r.sin_v <= trig_lookup(idx_r[DEPTH_BITS-1 -: 2], idx_r[QTR_BITS-1:0]);
      trig_r.cos_v <= trig_lookup(idx_r[DEPTH_BITS-1 -: 2] + 2'd1, idx_r[QTR_BITS-1:0]);
    end
  end

  assign trig = trig_r;

endmodule

// ===== rtl/m7qp_rot.sv =====
`timescale 1ns / 1ps
// One plane rotation of a coordinate pair with Q2.30 sine and cosine.
// Products are registered, then summed and rounded. Depends on m7qp_pkg.
module m7qp_rot import m7qp_pkg::*; (
  input  logic   clk,
  input  logic   en,
  input  coord_t a,
  input  coord_t b,
  input  trig_t  trig,
  output coord_t a_rot,
  output coord_t b_rot
);

  logic signed [PROD_W-1:0] ca_r;
  logic signed [PROD_W-1:0] sb_r;
  logic signed [PROD_W-1:0] sa_r;
  logic signed [PROD_W-1:0] cb_r;
  logic signed [PROD_W+1:0] an;
  logic signed [PROD_W+1:0] bn;
  coord_t                   a_r;
  coord_t                   b_r;

  always_comb begin
    an = (PROD_W+2)'(ca_r) - (PROD_W+2)'(sb_r) + (PROD_W+2)'(1 << 29);
    bn = (PROD_W+2)'(sa_r) + (PROD_W+2)'(cb_r) + (PROD_W+2)'(1 << 29);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ca_r <= PROD_W'(trig.cos_v) * PROD_W'(a);
      sb_r <= PROD_W'(trig.sin_v) * PROD_W'(b);
      sa_r <= PROD_W'(trig.sin_v) * PROD_W'(a);
      cb_r <= PROD_W'(trig.cos_v) * PROD_W'(b);
      a_r  <= CW'(an >>> 30);
      b_r  <= CW'(bn >>> 30);
    end
  end

  assign a_rot = a_r;
  assign b_rot = b_r;

endmodule

// ===== rtl/m7qp_proj.sv =====
`timescale 1ns / 1ps
// Perspective projection of one coordinate: depth clamp, scale products, pipelined
// restoring divide with one quotient bit per stage, rounding and saturation. Uses m7qp_pkg.
module m7qp_proj import m7qp_pkg::*; (
  input  logic                       clk,
  input  logic                       en,
  input  coord_t                     p,
  input  coord_t                     z,
  input  logic signed [FIELD_W-1:0]  focal,
  input  logic [SIZE_W-1:0]          size,
  output logic signed [SCREEN_W-1:0] res
);

  logic [CW-2:0]             zc;
  logic [CW-1:0]             pa;
  logic [FIELD_W-1:0]        fa;
  logic [CW+FIELD_W-1:0]     pm_r;
  logic [CW-2:0]             zc1_r;
  logic                      neg1_r;
  logic [MAG_W-1:0]          mag;
  logic [DIV_W-1:0]          rem_r [QUO_W];
  logic [DVS_W-1:0]          dv_r  [QUO_W];
  logic [QUO_W-1:0]          quo_r [QUO_W+1];
  logic                      neg_r [QUO_W+1];
  logic [EXT_W-1:0]          sh    [QUO_W];
  logic [QUO_W-1:0]          ge;
  logic [QUO_W-1:0]          q;
  logic signed [SCREEN_W-1:0] res_nxt;
  logic signed [SCREEN_W-1:0] res_r;

  always_comb begin
    zc  = (z < coord_t'(ZMIN)) ? (CW-1)'(ZMIN) : z[CW-2:0];
    pa  = p[CW-1] ? CW'(-p) : CW'(p);
    fa  = focal[FIELD_W-1] ? FIELD_W'(-focal) : FIELD_W'(focal);
    mag = MAG_W'(pm_r) * MAG_W'(size);
    for (int j = 0; j < QUO_W; j++) begin
      sh[j] = EXT_W'(dv_r[j]) << (QUO_W - 1 - j);
      ge[j] = EXT_W'(rem_r[j]) >= sh[j];
    end
    q = quo_r[QUO_W];
    if (neg_r[QUO_W]) begin
      if (q > QUO_W'(64'h8000_0000)) begin
        res_nxt = 32'sh8000_0000;
      end else begin
        res_nxt = -SCREEN_W'(q);
      end
    end else if (q >= QUO_W'(64'h8000_0000)) begin
      res_nxt = 32'sh7FFF_FFFF;
    end else begin
      res_nxt = SCREEN_W'(q);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pm_r     <= (CW+FIELD_W)'(pa) * (CW+FIELD_W)'(fa);
      zc1_r    <= zc;
      neg1_r   <= p[CW-1] ^ focal[FIELD_W-1];
      rem_r[0] <= (DIV_W'(mag) << 8) + (DIV_W'(zc1_r) << (FRAC_BITS - 1));
      dv_r[0]  <= DVS_W'(zc1_r) << FRAC_BITS;
      quo_r[0] <= '0;
      neg_r[0] <= neg1_r;
      for (int j = 0; j < QUO_W; j++) begin
        if (j < QUO_W - 1) begin
          rem_r[j+1] <= ge[j] ? DIV_W'(EXT_W'(rem_r[j]) - sh[j]) : rem_r[j];
          dv_r[j+1]  <= dv_r[j];
        end
        quo_r[j+1] <= {quo_r[j][QUO_W-2:0], ge[j]};
        neg_r[j+1] <= neg_r[j];
      end
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule
